// File: sv/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Types and codes shared by the counting semaphore table unit.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int IDX_W     = 4;   // width of an entry index on the ports
  localparam int IDX_REACH = 16;  // entries a port index can address
  localparam int OUT_CNT_W = 16;  // width of the count reported per item

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_V     = 2'd2,
    OP_P     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NONE_FREE   = 3'd1,
    ST_NOT_ALLOC   = 3'd2,
    ST_WOULD_BLOCK = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_e;

  typedef struct packed {
    op_e              opcode;
    logic [IDX_W-1:0] sem_index;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [IDX_W-1:0]     result_index;
    logic [OUT_CNT_W-1:0] count_after;
  } rsp_t;

  // Table write command from the execute logic.
  typedef struct packed {
    logic             flag_we;
    logic             flag_val;
    logic             cnt_we;
    logic [IDX_W-1:0] idx;
  } tbl_wr_t;

endpackage

// File: sv/counting_semaphore_table_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table_unit
// Table of counting semaphores with allocate, free, V and P requests.
// ----------------------------------------------------------------------------
// The unit takes one item (opcode plus entry index) at every rising edge at
// which start is high; busy never rises, so an item may be issued in every
// cycle, one item per cycle sustained. Each item runs through an input
// register and a single execute pass (lowest-free search plus one count
// update) into the result register: done_o rises at the first rising edge
// after the item was taken and stays high for exactly one cycle, and the
// result must be captured at the edge that ends that cycle since the unit
// cannot hold it. Results come back in issue order.
// Each item sees the table as left by the item before it. Only the lowest
// min(NUM_SEMS, 16) entries exist; free, V or P on a higher index reports
// not-allocated with a zero count. count_after carries the low 16 bits of the
// COUNT_WIDTH-bit count. Reset frees every entry and zeroes every count.
module counting_semaphore_table_unit #(
  parameter int NUM_SEMS    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  csem_pkg::req_t  req_i,
  output logic            done_o,
  output csem_pkg::rsp_t  rsp_o
);
  import csem_pkg::*;

  localparam int TABLE_SIZE = (NUM_SEMS < IDX_REACH) ? NUM_SEMS : IDX_REACH;
  localparam logic [IDX_W:0] TBL_LIMIT = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Input register
  logic valid_q;
  req_t req_q;

  // Result register
  logic done_q;
  rsp_t rsp_q;
  rsp_t rsp_d;

  // Table interface
  logic [TABLE_SIZE-1:0]  in_use;
  logic                   any_free;
  logic [IDX_W-1:0]       alloc_idx;
  logic [IDX_W-1:0]       rd_idx;
  logic                   cur_flag;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  tbl_wr_t                wr;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic [COUNT_WIDTH-1:0] out_cnt;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0] out_cnt_ext;
  logic                   idx_ok;

  assign busy = 1'b0;

  // Capture the item; payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  csem_prio_enc #(
    .N (TABLE_SIZE)
  ) u_prio_enc (
    .free_i     (~in_use),
    .any_free_o (any_free),
    .idx_o      (alloc_idx)
  );

  // Read the granted entry on allocate, the addressed one otherwise.
  assign rd_idx = (req_q.opcode == OP_ALLOC) ? alloc_idx : req_q.sem_index;
  assign idx_ok = {1'b0, req_q.sem_index} < TBL_LIMIT;

  csem_table #(
    .TABLE_SIZE  (TABLE_SIZE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .wr_i      (wr),
    .wr_cnt_i  (new_cnt),
    .in_use_o  (in_use),
    .rd_flag_o (cur_flag),
    .rd_cnt_o  (cur_cnt)
  );

  // Execute pass: decide status, table update and reported count.
  always_comb begin
    wr                 = '0;
    wr.idx             = rd_idx;
    new_cnt            = cur_cnt;
    out_cnt            = cur_cnt;
    rsp_d.status       = ST_OK;
    rsp_d.result_index = req_q.sem_index;
    if (req_q.opcode == OP_ALLOC) begin
      if (any_free) begin
        // Claim the lowest free entry, keep its count.
        wr.flag_we         = 1'b1;
        wr.flag_val        = 1'b1;
        rsp_d.result_index = alloc_idx;
      end else begin
        rsp_d.status       = ST_NONE_FREE;
        rsp_d.result_index = '0;
        out_cnt            = '0;
      end
    end else if (!idx_ok) begin
      // Entry does not exist: report and drop.
      rsp_d.status = ST_NOT_ALLOC;
      out_cnt      = '0;
    end else begin
      unique case (req_q.opcode)
        OP_FREE: begin
          wr.flag_we  = 1'b1;
          wr.flag_val = 1'b0;
        end
        OP_V: begin
          if (!cur_flag) begin
            rsp_d.status = ST_NOT_ALLOC;
          end else if (cur_cnt == COUNT_MAX) begin
            rsp_d.status = ST_OVERFLOW;
          end else begin
            new_cnt   = cur_cnt + COUNT_WIDTH'(1);
            out_cnt   = new_cnt;
            wr.cnt_we = 1'b1;
          end
        end
        OP_P: begin
          if (!cur_flag) begin
            rsp_d.status = ST_NOT_ALLOC;
          end else if (cur_cnt == '0) begin
            rsp_d.status = ST_WOULD_BLOCK;
          end else begin
            new_cnt   = cur_cnt - COUNT_WIDTH'(1);
            out_cnt   = new_cnt;
            wr.cnt_we = 1'b1;
          end
        end
        default: begin
          rsp_d.status = ST_NOT_ALLOC;
        end
      endcase
    end
    // Only a live item touches the table.
    wr.flag_we = wr.flag_we && valid_q;
    wr.cnt_we  = wr.cnt_we && valid_q;
    // Report the low bits of the count, zero-extended when narrower.
    out_cnt_ext       = {{OUT_CNT_W{1'b0}}, out_cnt};
    rsp_d.count_after = out_cnt_ext[OUT_CNT_W-1:0];
  end

  // Result register: strobe for one cycle per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  a_one_result_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> done_q)
    else $error("item in execute stage produced no result");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(valid_q))
    else $error("result strobe without an item");

  a_none_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status == ST_NONE_FREE) |->
      (rsp_q.result_index == '0 && rsp_q.count_after == '0))
    else $error("none-free result carries index or count");

  a_overflow_on_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status == ST_OVERFLOW) |-> $past(req_q.opcode == OP_V))
    else $error("overflow reported for an item other than V");

  a_block_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status == ST_WOULD_BLOCK) |->
      (rsp_q.count_after == '0 && $past(req_q.opcode == OP_P)))
    else $error("would-block result with nonzero count or wrong opcode");
`endif

endmodule

// File: sv/csem_prio_enc.sv
// ----------------------------------------------------------------------------
// csem_prio_enc
// Finds the lowest-numbered free semaphore entry.
// ----------------------------------------------------------------------------
module csem_prio_enc #(
  parameter int N = 16
) (
  input  logic [N-1:0]                free_i,
  output logic                        any_free_o,
  output logic [csem_pkg::IDX_W-1:0]  idx_o
);
  import csem_pkg::*;

  assign any_free_o = |free_i;

  // Scan from the top so the lowest set bit wins.
  always_comb begin
    idx_o = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (free_i[i]) begin
        idx_o = IDX_W'(i);
      end
    end
  end

endmodule

// File: sv/csem_table.sv
// ----------------------------------------------------------------------------
// csem_table
// In-use flags and counts of the semaphore entries, one read and one write
// port.
// ----------------------------------------------------------------------------
module csem_table #(
  parameter int TABLE_SIZE  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [csem_pkg::IDX_W-1:0]  rd_idx_i,
  input  csem_pkg::tbl_wr_t           wr_i,
  input  logic [COUNT_WIDTH-1:0]      wr_cnt_i,
  output logic [TABLE_SIZE-1:0]       in_use_o,
  output logic                        rd_flag_o,
  output logic [COUNT_WIDTH-1:0]      rd_cnt_o
);
  import csem_pkg::*;

  localparam int TBL_IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [IDX_W:0] TBL_LIMIT = (IDX_W + 1)'(TABLE_SIZE);

  logic [TABLE_SIZE-1:0]  flags_q;
  logic [COUNT_WIDTH-1:0] cnt_q [TABLE_SIZE];

  logic                 rd_ok;
  logic                 wr_ok;
  logic [TBL_IDX_W-1:0] ra;
  logic [TBL_IDX_W-1:0] wa;

  assign rd_ok = {1'b0, rd_idx_i} < TBL_LIMIT;
  assign wr_ok = {1'b0, wr_i.idx} < TBL_LIMIT;
  assign ra    = rd_idx_i[TBL_IDX_W-1:0];
  assign wa    = wr_i.idx[TBL_IDX_W-1:0];

  assign in_use_o  = flags_q;
  assign rd_flag_o = rd_ok ? flags_q[ra] : 1'b0;
  assign rd_cnt_o  = rd_ok ? cnt_q[ra] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (wr_i.flag_we && wr_ok) begin
        flags_q[wa] <= wr_i.flag_val;
      end
      if (wr_i.cnt_we && wr_ok) begin
        cnt_q[wa] <= wr_cnt_i;
      end
    end
  end

endmodule

// File: dv/counting_semaphore_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table_unit_tb
// Self-checking bench for the counting semaphore table unit.
// ----------------------------------------------------------------------------
// A directed sequence walks the table through its corner cases. It covers
// requests on free entries, freeing an entry that is already free, P on a
// zero count, filling the table up to the none-free status, and a short
// count climb with the count kept across free and allocate. Random requests
// follow; most of them are aimed at entries that are currently allocated. A
// local model of the table predicts every result, and results are compared
// in issue order.
// ----------------------------------------------------------------------------
module counting_semaphore_table_unit_tb;
  import csem_pkg::*;

  localparam int NUM_SEMS    = 16;
  localparam int COUNT_W     = 16;
  localparam int TBL_SIZE    = (NUM_SEMS < IDX_REACH) ? NUM_SEMS : IDX_REACH;
  localparam int RAND_ITEMS  = 1760;
  localparam int STALL_LIMIT = 1000;  // cycles with neither an item taken nor a result
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // One row of the directed table: a request, how often to repeat it, and
  // optionally the result typed in by hand.
  typedef struct {
    req_t        req;
    int unsigned reps;
    bit          typed;
    rsp_t        rsp;
  } step_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic done_o;
  rsp_t rsp_o;

  // Shadow copy of the table, advanced once per accepted item.
  bit               sem_in_use [NUM_SEMS];
  logic [COUNT_W-1:0] sem_cnt  [NUM_SEMS];

  rsp_t  owed_rsps [$];   // results still to come, oldest first
  step_t plan [$];

  int mismatches   = 0;
  int items_sent   = 0;
  int rsps_seen    = 0;
  int stall_cycles = 0;
  int status_seen [5];
  bit idle_on      = 1'b1;

  always #5 clk_i = ~clk_i;

  counting_semaphore_table_unit #(
    .NUM_SEMS   (NUM_SEMS),
    .COUNT_WIDTH(COUNT_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // Advance the shadow table by one request and return the result it owes.
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    bit   found;
    int   i;
    i = r.sem_index;
    o.status       = ST_OK;
    o.result_index = r.sem_index;
    o.count_after  = '0;
    found          = 1'b0;
    if (r.opcode == OP_ALLOC) begin
      // Grant the lowest free entry; its count is kept from before.
      for (int k = 0; k < TBL_SIZE; k++) begin
        if (!found && !sem_in_use[k]) begin
          found          = 1'b1;
          sem_in_use[k]  = 1'b1;
          o.result_index = IDX_W'(k);
          o.count_after  = OUT_CNT_W'(sem_cnt[k]);
        end
      end
      if (!found) begin
        o.status       = ST_NONE_FREE;
        o.result_index = '0;
      end
    end else if (i >= TBL_SIZE) begin
      o.status = ST_NOT_ALLOC;
    end else if (r.opcode == OP_FREE) begin
      sem_in_use[i] = 1'b0;
      o.count_after = OUT_CNT_W'(sem_cnt[i]);
    end else if (!sem_in_use[i]) begin
      o.status      = ST_NOT_ALLOC;
      o.count_after = OUT_CNT_W'(sem_cnt[i]);
    end else if (r.opcode == OP_V) begin
      if (sem_cnt[i] == COUNT_MAX) begin
        o.status = ST_OVERFLOW;
      end else begin
        sem_cnt[i] = sem_cnt[i] + 1'b1;
      end
      o.count_after = OUT_CNT_W'(sem_cnt[i]);
    end else begin
      if (sem_cnt[i] == '0) begin
        o.status = ST_WOULD_BLOCK;
      end else begin
        sem_cnt[i] = sem_cnt[i] - 1'b1;
      end
      o.count_after = OUT_CNT_W'(sem_cnt[i]);
    end
    return o;
  endfunction

  task automatic add_step(input op_e op, input int idx, input int unsigned reps,
                          input bit typed, input status_e st = ST_OK,
                          input int ridx = 0, input int cnt = 0);
    step_t s;
    s.req.opcode       = op;
    s.req.sem_index    = IDX_W'(idx);
    s.reps             = reps;
    s.typed            = typed;
    s.rsp.status       = st;
    s.rsp.result_index = IDX_W'(ridx);
    s.rsp.count_after  = OUT_CNT_W'(cnt);
    plan.push_back(s);
  endtask

  // Random request; three in four hit an allocated entry when there is one.
  function automatic req_t random_request();
    req_t r;
    int   live [$];
    int   pick;
    for (int k = 0; k < TBL_SIZE; k++) begin
      if (sem_in_use[k]) live.push_back(k);
    end
    pick = $urandom_range(99);
    if (pick < 20)      r.opcode = OP_ALLOC;
    else if (pick < 35) r.opcode = OP_FREE;
    else if (pick < 68) r.opcode = OP_V;
    else                r.opcode = OP_P;
    if (live.size() != 0 && $urandom_range(3) != 0) begin
      r.sem_index = IDX_W'(live[$urandom_range(live.size() - 1)]);
    end else begin
      r.sem_index = IDX_W'($urandom_range(15));
    end
    return r;
  endfunction

  // Drive one item and hold it until the unit takes it.
  task automatic issue(input req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
  endtask

  // Drop start for a random pause after about 20 items in a hundred, while idling is on.
  task automatic maybe_pause();
    if (idle_on && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_and_predict(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t pred;
    issue(r);
    pred = apply_request(r);
    owed_rsps.push_back(typed ? typed_rsp : pred);
    maybe_pause();
  endtask

  task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch (%s): want st=%0d idx=%0d cnt=%0d, got st=%0d idx=%0d cnt=%0d",
               $realtime, what, want.status, want.result_index, want.count_after,
               got.status, got.result_index, got.count_after);
    end
  endtask

  // Result checker: every strobe must match the oldest owed result.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      rsps_seen++;
      if (int'(rsp_o.status) < 5) status_seen[int'(rsp_o.status)]++;
      if (owed_rsps.size() == 0) begin
        want = '0;
        report_mismatch("result with nothing owed", want, rsp_o);
      end else begin
        want = owed_rsps.pop_front();
        if (rsp_o.status !== want.status)             report_mismatch("status", want, rsp_o);
        else if (rsp_o.result_index !== want.result_index) report_mismatch("index", want, rsp_o);
        else if (rsp_o.count_after !== want.count_after)   report_mismatch("count", want, rsp_o);
      end
    end
  end

  // Watchdog: end the run if the unit neither takes items nor answers.
  always @(posedge clk_i) begin
    if (!rst_ni || (start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results owed",
                 stall_cycles, owed_rsps.size());
        $display("FAIL counting_semaphore_table_unit");
        $finish;
      end
    end
  end

  initial begin
    rsp_t none;
    none = '0;
    for (int k = 0; k < NUM_SEMS; k++) begin
      sem_in_use[k] = 1'b0;
      sem_cnt[k]    = '0;
    end

    // Directed table. Typed rows are read straight off the spec; the rest go
    // through the shadow model.
    add_step(OP_P,     3,  1, 1, ST_NOT_ALLOC,   3,  0);  // P on a free entry
    add_step(OP_V,     15, 1, 1, ST_NOT_ALLOC,   15, 0);  // V on a free entry
    add_step(OP_FREE,  9,  1, 1, ST_OK,          9,  0);  // free of a free entry
    add_step(OP_ALLOC, 6,  1, 1, ST_OK,          0,  0);  // index ignored on allocate
    add_step(OP_P,     0,  1, 1, ST_WOULD_BLOCK, 0,  0);  // P on zero count
    add_step(OP_V,     0,  1, 1, ST_OK,          0,  1);
    add_step(OP_P,     0,  1, 1, ST_OK,          0,  0);
    add_step(OP_ALLOC, 0, 15, 0);                          // fill entries 1..15
    add_step(OP_ALLOC, 0,  1, 1, ST_NONE_FREE,   0,  0);  // table full
    add_step(OP_V,     15, 3, 0);                          // climb to three
    add_step(OP_P,     15, 1, 1, ST_OK,          15, 2);
    add_step(OP_V,     15, 1, 1, ST_OK,          15, 3);
    add_step(OP_FREE,  15, 1, 1, ST_OK,          15, 3);
    add_step(OP_V,     15, 1, 1, ST_NOT_ALLOC,   15, 3);  // kept count on free entry
    add_step(OP_P,     15, 1, 1, ST_NOT_ALLOC,   15, 3);
    add_step(OP_ALLOC, 0,  1, 1, ST_OK,          15, 3);  // grant keeps the count
    add_step(OP_FREE,  4,  1, 1, ST_OK,          4,  0);
    add_step(OP_FREE,  15, 1, 1, ST_OK,          15, 3);
    add_step(OP_ALLOC, 0,  1, 1, ST_OK,          4,  0);  // lowest free wins
    add_step(OP_ALLOC, 0,  1, 1, ST_OK,          15, 3);
    add_step(OP_P,     15, 1, 1, ST_OK,          15, 2);

    // Hold reset low, then release it on a rising edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[n]) begin
      for (int unsigned rep = 0; rep < plan[n].reps; rep++) begin
        send_and_predict(plan[n].req, plan[n].typed, plan[n].rsp);
      end
    end

    // Random part; a stretch in the middle runs back to back with no idling.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_on = !(n >= 700 && n < 1100);
      send_and_predict(random_request(), 1'b0, none);
    end
    start <= 1'b0;

    // Drain: wait for every owed result, then let the pipeline settle.
    while (owed_rsps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d items and %0d results: ok %0d, none-free %0d, not-allocated %0d,",
             items_sent, rsps_seen, status_seen[0], status_seen[1], status_seen[2]);
    $display("  would-block %0d, overflow %0d; %0d mismatches.",
             status_seen[3], status_seen[4], mismatches);
    if (mismatches == 0 && owed_rsps.size() == 0) begin
      $display("PASS counting_semaphore_table_unit");
    end else begin
      $display("FAIL counting_semaphore_table_unit");
    end
    $finish;
  end

endmodule

// File: files.f
sv/csem_pkg.sv
sv/csem_prio_enc.sv
sv/csem_table.sv
sv/counting_semaphore_table_unit.sv
dv/counting_semaphore_table_unit_tb.sv
